// ----- rtl/skt_pkg.sv -----
// Shared types and codes for the sorted key table core.
package skt_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic        [30:0] target;
    } entry_t;

    // Query travelling down the cell chain, with the result it gathers.
    typedef struct packed {
        logic               active;
        logic               stop;
        logic               hit;
        logic               opcode;
        entry_t             item;
        logic signed [31:0] found_low;
        logic signed [31:0] found_high;
        logic        [30:0] found_target;
    } token_t;

endpackage

// ----- rtl/skt_cell.sv -----
// One table slot: holds an entry and passes the search token to its neighbour.
module skt_cell #(
    parameter int CAPACITY = 64,
    parameter int INDEX    = 0,
    localparam int IW      = $clog2(CAPACITY + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IW-1:0]   count,
    input  skt_pkg::token_t tok_in,
    input  logic [IW-1:0]   pos_in,
    output skt_pkg::token_t tok_out,
    output logic [IW-1:0]   pos_out,
    input  logic            commit_en,
    input  logic [IW-1:0]   commit_pos,
    input  skt_pkg::entry_t left_entry,
    input  skt_pkg::entry_t new_entry,
    output skt_pkg::entry_t entry
);

    skt_pkg::token_t tok_reg;
    skt_pkg::token_t tok_next;
    logic [IW-1:0]   pos_reg;
    logic [IW-1:0]   pos_next;
    skt_pkg::entry_t entry_reg;
    skt_pkg::entry_t entry_next;
    logic            live;
    logic            less;

    assign live = IW'(INDEX) < count;
    assign less = live && ($signed(entry_reg.key) < $signed(tok_in.item.key));

    // The token stops at the first slot whose key is not below the query.
    always_comb
    begin
        tok_next = tok_in;
        pos_next = pos_in;
        if (tok_in.active && !tok_in.stop && !less)
        begin
            tok_next.stop = 1'b1;
            pos_next      = IW'(INDEX);
            if (live && (entry_reg.key == tok_in.item.key))
            begin
                tok_next.hit          = 1'b1;
                tok_next.found_low    = entry_reg.low;
                tok_next.found_high   = entry_reg.high;
                tok_next.found_target = entry_reg.target;
            end
        end
    end

    // On an insert, the gap slot takes the new entry; slots above shift right.
    always_comb
    begin
        entry_next = entry_reg;
        if (commit_en)
        begin
            if (IW'(INDEX) > commit_pos)
            begin
                entry_next = left_entry;
            end
            else if (IW'(INDEX) == commit_pos)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign pos_out = pos_reg;
    assign entry   = entry_reg;

endmodule

// ----- rtl/sorted_key_table_insert_lookup_core.sv -----
// Top level of the sorted key table with lookup and insert.
//
// The input channel (in_valid, in_ready) carries one transaction per request:
// opcode selects lookup or insert of key, with range_low, range_high and
// target_id stored on insert. The output channel (out_valid, out_ready) returns
// exactly one transaction per request: status, position and the found fields.
// Entries sit in a row of CAPACITY cells kept sorted by signed key. A request
// enters cell 0 and moves one cell per cycle; it stops at the first cell whose
// key is not below it, which gives the hit or the insertion point. After the
// last cell the result is decided and, for an accepted insert, every cell
// above the gap takes its left neighbour's entry and the gap cell takes the
// new entry, all in the same cycle. One request is in work at a time: a new
// request is taken only once the previous one has walked the whole cell
// chain and its result has moved into the output register.
// Reset clears the entry count, so the table starts empty; entry contents are
// not cleared and need no clearing pass.
// The result waits in an output register; while the receiver stalls, a new
// request may still be accepted and walk the chain, and it waits at the end
// of the chain until the output register is free.
module sorted_key_table_insert_lookup_core #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [31:0] key,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    input  logic        [30:0] target_id,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [1:0]  status,
    output logic        [6:0]  position,
    output logic signed [31:0] found_low,
    output logic signed [31:0] found_high,
    output logic        [30:0] found_target
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int PW = (IW > 7) ? IW : 7;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [IW-1:0]           count_reg;
    logic [IW-1:0]           count_next;
    skt_pkg::token_t         res_tok_reg;
    logic [IW-1:0]           res_pos_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    skt_pkg::status_t        status_reg;
    logic [6:0]              position_reg;
    logic signed [31:0]      found_low_reg;
    logic signed [31:0]      found_high_reg;
    logic [30:0]             found_target_reg;

    skt_pkg::token_t         tok_w [0:CAPACITY];
    logic [IW-1:0]           pos_w [0:CAPACITY];
    skt_pkg::entry_t         ent_w [0:CAPACITY-1];

    logic                    accept;
    logic                    capture;
    logic                    slot_free;
    logic                    full;
    logic                    insert_ok;
    logic                    commit_en;
    skt_pkg::status_t        res_status;
    logic signed [31:0]      res_low;
    logic signed [31:0]      res_high;
    logic [30:0]             res_target;
    logic [PW-1:0]           pos_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign capture   = (state_reg == S_WALK) && tok_w[CAPACITY].active;
    assign slot_free = !out_valid_reg || out_ready;
    assign full      = (count_reg == IW'(CAPACITY));

    // The request enters the chain with an empty result.
    always_comb
    begin
        tok_w[0]                  = '0;
        tok_w[0].active           = accept;
        tok_w[0].opcode           = opcode;
        tok_w[0].item.key         = key;
        tok_w[0].item.low         = range_low;
        tok_w[0].item.high        = range_high;
        tok_w[0].item.target      = target_id;
    end
    assign pos_w[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        skt_pkg::entry_t left;
        if (i == 0)
        begin : g_first
            assign left = res_tok_reg.item;
        end
        else
        begin : g_rest
            assign left = ent_w[i-1];
        end

        skt_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .count      (count_reg),
            .tok_in     (tok_w[i]),
            .pos_in     (pos_w[i]),
            .tok_out    (tok_w[i+1]),
            .pos_out    (pos_w[i+1]),
            .commit_en  (commit_en),
            .commit_pos (res_pos_reg),
            .left_entry (left),
            .new_entry  (res_tok_reg.item),
            .entry      (ent_w[i])
        );
    end

    // Decide the outcome once the request has passed every cell.
    always_comb
    begin
        res_status = skt_pkg::ST_OK;
        res_low    = '0;
        res_high   = '0;
        res_target = '0;
        insert_ok  = 1'b0;
        if (res_tok_reg.hit)
        begin
            res_status = (res_tok_reg.opcode == skt_pkg::OP_INSERT) ?
                         skt_pkg::ST_DUPLICATE : skt_pkg::ST_OK;
            res_low    = res_tok_reg.found_low;
            res_high   = res_tok_reg.found_high;
            res_target = res_tok_reg.found_target;
        end
        else if (res_tok_reg.opcode == skt_pkg::OP_LOOKUP)
        begin
            res_status = skt_pkg::ST_NOT_FOUND;
        end
        else if (full)
        begin
            res_status = skt_pkg::ST_FULL;
        end
        else
        begin
            insert_ok  = 1'b1;
            res_low    = res_tok_reg.item.low;
            res_high   = res_tok_reg.item.high;
            res_target = res_tok_reg.item.target;
        end
    end

    assign commit_en = (state_reg == S_DONE) && slot_free && insert_ok;
    assign pos_ext   = PW'(res_pos_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (capture)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_DONE) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A request that passes every cell unstopped belongs at the end of the table.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            res_tok_reg <= tok_w[CAPACITY];
            res_pos_reg <= tok_w[CAPACITY].stop ? pos_w[CAPACITY] : IW'(CAPACITY);
        end
        if ((state_reg == S_DONE) && slot_free)
        begin
            status_reg       <= res_status;
            position_reg     <= pos_ext[6:0];
            found_low_reg    <= res_low;
            found_high_reg   <= res_high;
            found_target_reg <= res_target;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position     = position_reg;
    assign found_low    = found_low_reg;
    assign found_high   = found_high_reg;
    assign found_target = found_target_reg;

endmodule

// ----- rtl/skt_checker.sv -----
// Port-level checks for the sorted key table core, with their bind.
module skt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic        [1:0]  status,
    input logic        [6:0]  position,
    input logic signed [31:0] found_low,
    input logic signed [31:0] found_high,
    input logic        [30:0] found_target
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position))
        else $error("result changed while stalled");

    // Only one request is in work: the input closes right after a transaction.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in work");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == skt_pkg::ST_NOT_FOUND) |->
        (found_low == 0) && (found_high == 0) && (found_target == 0))
        else $error("lookup miss returned entry data");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == skt_pkg::ST_FULL) |->
        (found_low == 0) && (found_high == 0) && (found_target == 0))
        else $error("refused insert returned entry data");

endmodule

bind sorted_key_table_insert_lookup_core skt_checker u_skt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .position     (position),
    .found_low    (found_low),
    .found_high   (found_high),
    .found_target (found_target)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key table lookup and insert core.
module testbench;

    // The core is built with its default capacity. One request is in work at a
    // time and each one walks the whole cell chain before its result appears.
    localparam int CAPACITY    = 64;
    localparam int LATENCY     = CAPACITY + 1;
    // Cycles with no transaction on either channel before the run is abandoned.
    // A correct run never goes much beyond one walk plus one stall burst on
    // each side.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 430;
    localparam int CALM_ITEMS   = 80;

    localparam logic signed [31:0] KEY_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX    = 32'sh7fff_ffff;
    localparam logic        [30:0] TARGET_MAX = 31'h7fff_ffff;

    typedef struct {
        skt_pkg::status_t   status;
        logic        [6:0]  position;
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic        [30:0] target;
    } reply_t;

    // Keeps its own sorted copy of the table and the replies it still owes.
    class sorted_table_scoreboard;
        logic signed [31:0] keys    [CAPACITY];
        logic signed [31:0] lows    [CAPACITY];
        logic signed [31:0] highs   [CAPACITY];
        logic        [30:0] targets [CAPACITY];
        int unsigned        count = 0;
        int unsigned        mismatches = 0;
        reply_t             pending_replies [$];

        // Works out the reply to one accepted request and applies an insert.
        function void take_request(input logic op, input logic signed [31:0] req_key,
                                   input logic signed [31:0] req_low,
                                   input logic signed [31:0] req_high,
                                   input logic [30:0] req_target);
            reply_t      r;
            int unsigned slot;
            int          i;
            bit          present;
            slot = 0;
            while (slot < count && keys[slot] < req_key)
                slot++;
            present    = (slot < count) && (keys[slot] == req_key);
            r.position = 7'(slot);
            r.low      = '0;
            r.high     = '0;
            r.target   = '0;
            if (present)
            begin
                if (op == skt_pkg::OP_INSERT)
                    r.status = skt_pkg::ST_DUPLICATE;
                else
                    r.status = skt_pkg::ST_OK;
                r.low    = lows[slot];
                r.high   = highs[slot];
                r.target = targets[slot];
            end
            else if (op == skt_pkg::OP_LOOKUP)
                r.status = skt_pkg::ST_NOT_FOUND;
            else if (count >= CAPACITY)
                r.status = skt_pkg::ST_FULL;
            else
            begin
                for (i = count; i > slot; i--)
                begin
                    keys[i]    = keys[i - 1];
                    lows[i]    = lows[i - 1];
                    highs[i]   = highs[i - 1];
                    targets[i] = targets[i - 1];
                end
                keys[slot]    = req_key;
                lows[slot]    = req_low;
                highs[slot]   = req_high;
                targets[slot] = req_target;
                count++;
                r.status = skt_pkg::ST_OK;
                r.low    = req_low;
                r.high   = req_high;
                r.target = req_target;
            end
            pending_replies.push_back(r);
        endfunction

        // Compares one accepted reply with the oldest one still owed.
        function void match_response(input logic [1:0] got_status,
                                     input logic [6:0] got_position,
                                     input logic signed [31:0] got_low,
                                     input logic signed [31:0] got_high,
                                     input logic [30:0] got_target);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply with no request outstanding (status %0d position %0d)",
                             $realtime, got_status, got_position);
                return;
            end
            want = pending_replies.pop_front();
            if (2'(want.status) !== got_status || want.position !== got_position ||
                want.low !== got_low || want.high !== got_high ||
                want.target !== got_target)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: reply mismatch: expected status %s position %0d",
                             $realtime, want.status.name(), want.position);
                    $display("    expected low %0d high %0d target %0d",
                             want.low, want.high, want.target);
                    $display("    got status %0d position %0d low %0d high %0d target %0d",
                             got_status, got_position, got_low, got_high, got_target);
                end
            end
        endfunction

        // Returns a key that is in the table, or any key while it is empty.
        function logic signed [31:0] stored_key();
            if (count == 0)
                return $urandom;
            return keys[$urandom_range(0, count - 1)];
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic signed [31:0] key;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic        [30:0] target_id;
    logic               out_valid;
    logic               out_ready;
    logic        [1:0]  status;
    logic        [6:0]  position;
    logic signed [31:0] found_low;
    logic signed [31:0] found_high;
    logic        [30:0] found_target;

    sorted_table_scoreboard table_sb;
    int unsigned            quiet_cycles;
    // Once set, neither side idles any more, so the last stretch runs flat out.
    bit                     calm;
    // Cleared for whole blocks of requests to give stretches without idling.
    bit                     sender_idles;

    sorted_key_table_insert_lookup_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key         (key),
        .range_low   (range_low),
        .range_high  (range_high),
        .target_id   (target_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .found_low   (found_low),
        .found_high  (found_high),
        .found_target(found_target)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Every input holds a known value from time zero; the table is created
    // before the first rising edge so the monitor can always use it.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = skt_pkg::OP_LOOKUP;
        key          = '0;
        range_low    = '0;
        range_high   = '0;
        target_id    = '0;
        out_ready    = 1'b1;
        quiet_cycles = 0;
        calm         = 1'b0;
        sender_idles = 1'b1;
        table_sb     = new;
    end

    // Both channels are sampled at the rising edge, where the inputs driven at
    // the falling edge are settled. Each accepted request updates the predicted
    // table at once, in the order of acceptance, which is the order in which
    // the core serves them. The watchdog counts edges with no transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                table_sb.take_request(opcode, key, range_low, range_high, target_id);
            if (out_valid && out_ready)
                table_sb.match_response(status, position, found_low, found_high,
                                        found_target);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("** sorted_key_table_insert_lookup_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    // The receiver stalls in bursts. It switches now and then between a busy
    // mood and a steady one, so some long stretches see no stall at all. Because
    // a result takes a whole chain walk, the bursts land at every point of that
    // walk: while the request is in the chain, while the result waits in the
    // output register, and while the next request arrives.
    initial
    begin : receiver_stalls
        int burst;
        bit busy;
        busy = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                busy = !busy;
            if (!calm && busy && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 16);
                out_ready <= 1'b0;
                repeat (burst) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Idle cycles to leave before the next request on the input channel.
    function automatic int sender_gap();
        if (calm || !sender_idles || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    // Presents one request at the falling edge and holds it until it is taken.
    // With no gap, valid simply stays high from the previous transaction.
    task automatic send_request(input logic op, input logic signed [31:0] req_key,
                                input logic signed [31:0] req_low,
                                input logic signed [31:0] req_high,
                                input logic [30:0] req_target);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        opcode     <= op;
        key        <= req_key;
        range_low  <= req_low;
        range_high <= req_high;
        target_id  <= req_target;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    initial
    begin : stimulus
        int                 n;
        int                 pick;
        int                 offset;
        logic               op;
        logic signed [31:0] k;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The empty table is probed first, then the key
        // extremes go in with the field extremes as their payload, so both
        // ends of the table and its middle are populated early on.
        send_request(skt_pkg::OP_LOOKUP, 32'sd0, $urandom, $urandom, 31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, KEY_MIN, KEY_MAX, KEY_MIN, TARGET_MAX);
        send_request(skt_pkg::OP_INSERT, 32'sd0, KEY_MIN, KEY_MAX, TARGET_MAX);
        send_request(skt_pkg::OP_INSERT, KEY_MIN, KEY_MAX, KEY_MIN, 31'd0);
        send_request(skt_pkg::OP_INSERT, KEY_MAX, -32'sd1, 32'sd0, 31'h2aaa_aaaa);
        send_request(skt_pkg::OP_INSERT, -32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa,
                     31'h5555_5555);
        send_request(skt_pkg::OP_INSERT, 32'sd1, 32'sd1, -32'sd2, 31'd1);
        // Inserting keys that are already present must leave the table alone
        // and report the stored entry, at both ends and in the middle.
        send_request(skt_pkg::OP_INSERT, 32'sd0, 32'sd7, 32'sd8, 31'd9);
        send_request(skt_pkg::OP_INSERT, KEY_MAX, 32'sd0, 32'sd0, 31'd0);
        send_request(skt_pkg::OP_INSERT, KEY_MIN, KEY_MIN, KEY_MAX, TARGET_MAX);
        // Hits at the first, last and inner entries.
        send_request(skt_pkg::OP_LOOKUP, KEY_MIN, $urandom, $urandom, 31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, KEY_MAX, $urandom, $urandom, 31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, 32'sd0, $urandom, $urandom, 31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, -32'sd1, $urandom, $urandom, 31'($urandom));
        // Misses next to stored keys, so the insertion point lands in each gap.
        send_request(skt_pkg::OP_LOOKUP, KEY_MIN + 32'sd1, $urandom, $urandom,
                     31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, KEY_MAX - 32'sd1, $urandom, $urandom,
                     31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, 32'sd2, $urandom, $urandom, 31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, -32'sd2, $urandom, $urandom, 31'($urandom));
        // Inserts just inside both ends shift nearly the whole table or only its last entry.
        send_request(skt_pkg::OP_INSERT, KEY_MAX - 32'sd1, $urandom, $urandom,
                     31'($urandom));
        send_request(skt_pkg::OP_INSERT, KEY_MIN + 32'sd1, $urandom, $urandom,
                     31'($urandom));
        send_request(skt_pkg::OP_LOOKUP, KEY_MAX - 32'sd1, $urandom, $urandom,
                     31'($urandom));

        // Random part. Inserts are frequent enough that the table fills in the
        // first half; after that, inserts of new keys are refused as full and
        // inserts of stored keys still report duplicates. Keys mix fresh random
        // values, stored keys (hits and duplicates) and close neighbours of
        // stored keys, which mostly miss with insertion points between entries.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if (n % 40 == 0)
                sender_idles = ($urandom_range(0, 3) != 0);
            op   = ($urandom_range(0, 9) < 4) ? skt_pkg::OP_INSERT : skt_pkg::OP_LOOKUP;
            pick = $urandom_range(0, 9);
            offset = $urandom_range(0, 6) - 3;
            if (pick < 4)
                k = $urandom;
            else if (pick < 7)
                k = table_sb.stored_key();
            else if (pick < 9)
                k = table_sb.stored_key() + offset;
            else if (offset < 0)
                k = KEY_MIN - offset;
            else
                k = KEY_MAX - offset;
            send_request(op, k, $urandom, $urandom, 31'($urandom));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Wait for every owed reply, then one more walk's worth of cycles so
        // that any stray extra reply is caught. The watchdog bounds the wait.
        while (table_sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (table_sb.mismatches == 0 && table_sb.pending_replies.size() == 0)
            $display("** sorted_key_table_insert_lookup_core: PASSED **");
        else
            $display("** sorted_key_table_insert_lookup_core: FAILED **");
        $finish;
    end

endmodule
